// File: rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: session table shared definitions
// Sizes, operation codes, slot entry layout and identifier checks.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int CAPACITY   = 8;
    localparam int MAX_ID_LEN = 8;
    localparam int MIN_ID_LEN = 6;

    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int OP_W       = 2;
    localparam int KEY_W      = 64;
    localparam int LEN_W      = 4;
    localparam int TIME_W     = 32;
    localparam int OUT_CNT_W  = 4;
    localparam int NUM_BYTES  = KEY_W / 8;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

    localparam logic [OP_W-1:0] OP_TOUCH   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  key_len;
        logic [TIME_W-1:0] last_seen;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // 0-9, A-Z, a-z, '-', '_'
    function automatic logic char_allowed(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h5F;
    endfunction

    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < NUM_BYTES; b++)
        begin
            m[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic id_valid(input logic [KEY_W-1:0] chars,
                                      input logic [LEN_W-1:0] len);
        logic ok;
        ok = (len >= LEN_W'(MIN_ID_LEN)) && (len <= LEN_W'(MAX_ID_LEN));
        for (int b = 0; b < NUM_BYTES; b++)
        begin
            if (LEN_W'(b) < len && !char_allowed(chars[b*8 +: 8]))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// File: rtl/sts_if.sv
// ----------------------------------------------------------------------------
// sts_if: session table channel interfaces
// Request and response channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface sts_req_if
    import sts_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  id_chars;
    logic [LEN_W-1:0]  id_length;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, operation, id_chars, id_length, now_ms,
                    input ready);
    modport sink   (input valid, operation, id_chars, id_length, now_ms,
                    output ready);
endinterface

interface sts_rsp_if
    import sts_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [OUT_CNT_W-1:0] live_count;

    modport source (output valid, ok, live_count, input ready);
    modport sink   (input valid, ok, live_count, output ready);
endinterface

// File: rtl/session_table_with_timeout_lru_top.sv
// ----------------------------------------------------------------------------
// session_table_with_timeout_lru_top: LRU session table with idle expiry
// Touch / release / count / clear over a table of session slots held in RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                    | transfer when
//  --------+-----+--------------------------------------------+------------------
//  req     | in  | operation, id_chars, id_length, now_ms     | valid & ready
//  rsp     | out | ok, live_count                             | valid & ready
//  cfg     | in  | cfg_data (idle timeout, 0 stored as 1)     | cfg_we
//
//  Scan: touch (valid id), release (valid id) and count scan the slot RAM,
//  one read per cycle, before the next request can be taken. Clear and
//  rejected ids skip the scan.
//  Reset: active flags and count clear at once; RAM contents are only used
//  for active slots, so no clearing pass is needed.
//  Stalls: req is taken only in IDLE; a finished item waits in FINISH while
//  the previous response is still held on rsp.
// ----------------------------------------------------------------------------
module session_table_with_timeout_lru_top
    import sts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    sts_req_if.sink            req,
    sts_rsp_if.source          rsp,
    input  logic               cfg_we,
    input  logic [TIME_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // control state
    logic [1:0]          state_reg, state_next;
    logic [CAPACITY-1:0] active_reg, active_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W:0]      issue_reg, issue_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                found_reg, found_next;
    logic                free_found_reg, free_found_next;
    logic                lru_vld_reg, lru_vld_next;
    logic                rsp_vld_reg, rsp_vld_next;
    logic [TIME_W-1:0]   timeout_reg, timeout_next;

    // payload
    logic [OP_W-1:0]     op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                idv_reg;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]    lru_idx_reg, lru_idx_next;
    logic [TIME_W-1:0]   lru_time_reg, lru_time_next;
    logic                rsp_ok_reg, rsp_ok_next;
    logic [OUT_CNT_W-1:0] rsp_cnt_reg, rsp_cnt_next;

    // datapath
    logic                accept;
    logic                fin_go;
    logic                do_expire;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    slot_entry_t         ram_wentry;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;
    slot_entry_t         rd_entry;
    logic [TIME_W-1:0]   age;
    logic                slot_act;
    logic                slot_exp;
    logic                slot_eff;
    logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign fin_go    = (state_reg == ST_FINISH) && (!rsp_vld_reg || rsp.ready);
    assign do_expire = (op_reg == OP_TOUCH) || (op_reg == OP_COUNT);

    assign rsp.valid      = rsp_vld_reg;
    assign rsp.ok         = rsp_ok_reg;
    assign rsp.live_count = rsp_cnt_reg;

    assign ram_re   = (state_reg == ST_SCAN) && (issue_reg < (IDX_W+1)'(CAPACITY));
    assign rd_entry = slot_entry_t'(ram_rdata);
    assign age      = now_reg - rd_entry.last_seen;
    assign slot_act = active_reg[chk_idx_reg];
    assign slot_exp = do_expire && slot_act && (age > timeout_reg);
    assign slot_eff = slot_act && !slot_exp;

    sts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = issue_reg[IDX_W-1:0];
        found_next      = found_reg;
        free_found_next = free_found_reg;
        lru_vld_next    = lru_vld_reg;
        match_idx_next  = match_idx_reg;
        free_idx_next   = free_idx_reg;
        lru_idx_next    = lru_idx_reg;
        lru_time_next   = lru_time_reg;
        rsp_vld_next    = rsp_vld_reg;
        rsp_ok_next     = rsp_ok_reg;
        rsp_cnt_next    = rsp_cnt_reg;
        timeout_next    = timeout_reg;
        ram_we          = 1'b0;
        ram_waddr       = match_idx_reg;
        ram_wentry      = '{key: key_reg, key_len: len_reg, last_seen: now_reg};
        cnt_ext         = '0;

        if (cfg_we)
        begin
            timeout_next = (cfg_data == '0) ? TIME_W'(1) : cfg_data;
        end

        if (rsp_vld_reg && rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    issue_next      = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    lru_vld_next    = 1'b0;
                    // clear and rejected ids never look at the table
                    if (req.operation == OP_CLEAR ||
                        (req.operation != OP_COUNT && !id_valid(req.id_chars, req.id_length)))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ram_re)
                begin
                    issue_next   = issue_reg + 1'b1;
                    chk_vld_next = 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (slot_exp)
                    begin
                        active_next[chk_idx_reg] = 1'b0;
                        cnt_next = cnt_reg - 1'b1;
                    end
                    if (!found_reg && slot_eff && rd_entry.key_len == len_reg &&
                        rd_entry.key == key_reg)
                    begin
                        found_next     = 1'b1;
                        match_idx_next = chk_idx_reg;
                    end
                    if (!free_found_reg && !slot_eff)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    // strict less-than keeps the lowest index on ties
                    if (slot_eff && (!lru_vld_reg || rd_entry.last_seen < lru_time_reg))
                    begin
                        lru_vld_next  = 1'b1;
                        lru_idx_next  = chk_idx_reg;
                        lru_time_next = rd_entry.last_seen;
                    end
                    if (chk_idx_reg == IDX_W'(CAPACITY - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (fin_go)
                begin
                    rsp_ok_next = 1'b0;
                    case (op_reg)
                        OP_TOUCH:
                        begin
                            if (idv_reg)
                            begin
                                rsp_ok_next = 1'b1;
                                ram_we      = 1'b1;
                                if (found_reg)
                                begin
                                    ram_waddr = match_idx_reg;
                                end
                                else if (free_found_reg)
                                begin
                                    ram_waddr               = free_idx_reg;
                                    active_next[free_idx_reg] = 1'b1;
                                    cnt_next                = cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ram_waddr = lru_idx_reg;
                                end
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (idv_reg && found_reg)
                            begin
                                rsp_ok_next                = 1'b1;
                                active_next[match_idx_reg] = 1'b0;
                                cnt_next                   = cnt_reg - 1'b1;
                            end
                        end
                        OP_COUNT:
                        begin
                            rsp_ok_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            rsp_ok_next = 1'b1;
                            active_next = '0;
                            cnt_next    = '0;
                        end
                        default:
                        begin
                            rsp_ok_next = 1'b0;
                        end
                    endcase
                    cnt_ext      = {{OUT_CNT_W{1'b0}}, cnt_next};
                    rsp_cnt_next = cnt_ext[OUT_CNT_W-1:0];
                    rsp_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            cnt_reg        <= '0;
            issue_reg      <= '0;
            chk_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            lru_vld_reg    <= 1'b0;
            rsp_vld_reg    <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            cnt_reg        <= cnt_next;
            issue_reg      <= issue_next;
            chk_vld_reg    <= chk_vld_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            lru_vld_reg    <= lru_vld_next;
            rsp_vld_reg    <= rsp_vld_next;
            timeout_reg    <= timeout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            key_reg <= req.id_chars & byte_mask(req.id_length);
            len_reg <= req.id_length;
            now_reg <= req.now_ms;
            idv_reg <= id_valid(req.id_chars, req.id_length);
        end
        chk_idx_reg   <= chk_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        lru_idx_reg   <= lru_idx_next;
        lru_time_reg  <= lru_time_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_cnt_reg   <= rsp_cnt_next;
    end

    // running count tracks the active flags
    a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == 32'($countones(active_reg)))
        else $error("active count out of step with active flags");

    a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == ST_SCAN))
        else $error("slot check outside scan");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_vld_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("response raised outside finish");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && op_reg == OP_CLEAR) |=> (active_reg == '0))
        else $error("clear left active slots");

endmodule

// File: rtl/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram: generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: verif/session_table_with_timeout_lru_top_test.sv
// ----------------------------------------------------------------------------
// session_table_with_timeout_lru_top_test: session table self-checking bench
// Drives touch / release / count / clear transfers with random gaps on both
// channels. An in-bench model of the slot table predicts ok and live_count
// for every accepted request; each response is checked against the oldest
// prediction. The idle timeout is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module session_table_with_timeout_lru_top_test;
    import sts_pkg::*;

    // Stall watchdog: cycles without any transfer before the run is abandoned.
    // Slowest legal stretch is a long sender gap or a long response stall
    // plus a table scan, or a drain before a register write; this leaves a
    // wide margin.
    localparam int unsigned STALL_LIMIT  = 4000;
    // Cycles allowed after the last response before touching the register.
    localparam int unsigned SETTLE_TICKS = CAPACITY + 6;

    typedef struct packed {
        logic                 ok;
        logic [OUT_CNT_W-1:0] live_count;
    } session_reply_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [TIME_W-1:0] cfg_data;

    sts_req_if req_ch();
    sts_rsp_if rsp_ch();

    session_table_with_timeout_lru_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the slot table and the timeout register
    // ------------------------------------------------------------------
    logic              shadow_active [CAPACITY];
    logic [TIME_W-1:0] shadow_seen   [CAPACITY];
    logic [KEY_W-1:0]  shadow_key    [CAPACITY];
    logic [LEN_W-1:0]  shadow_len    [CAPACITY];
    logic [TIME_W-1:0] shadow_timeout;

    session_reply_t pending_replies[$];
    int unsigned    error_count;
    int unsigned    idle_ticks;
    bit             sender_burst;   // no sender gaps while set

    // Characters just outside the legal ranges, plus a few far-off ones.
    logic [7:0] odd_chars [10] = '{8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60,
                                   8'h7B, 8'h00, 8'hFF, 8'h2C, 8'h2E};

    // Random id pool used by the traffic phases.
    logic [KEY_W-1:0] pool_chars [12];
    logic [LEN_W-1:0] pool_len   [12];

    // ------------------------------------------------------------------
    // Prediction helpers
    // ------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] length_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_W / 8; b++)
        begin
            if (b < len)
                m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic logic legal_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "-" || c == "_";
    endfunction

    function automatic logic legal_id(input logic [KEY_W-1:0] chars,
                                      input logic [LEN_W-1:0] len);
        logic good;
        good = (len >= MIN_ID_LEN) && (len <= MAX_ID_LEN);
        for (int b = 0; b < KEY_W / 8; b++)
        begin
            if (b < len && !legal_char(chars[b*8 +: 8]))
                good = 1'b0;
        end
        return good;
    endfunction

    function automatic void wipe_shadow_slot(input int i);
        shadow_active[i] = 1'b0;
        shadow_seen[i]   = '0;
        shadow_key[i]    = '0;
        shadow_len[i]    = '0;
    endfunction

    // Idle expiry: wrapping age strictly above the timeout.
    function automatic void expire_idle(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        for (int i = 0; i < CAPACITY; i++)
        begin
            age = now - shadow_seen[i];
            if (shadow_active[i] && age > shadow_timeout)
                wipe_shadow_slot(i);
        end
    endfunction

    function automatic int find_session(input logic [KEY_W-1:0] key,
                                        input logic [LEN_W-1:0] len);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (shadow_active[i] && shadow_len[i] == len && shadow_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns the reply it earns.
    function automatic session_reply_t apply_request(input logic [OP_W-1:0]   op,
                                                     input logic [KEY_W-1:0]  chars,
                                                     input logic [LEN_W-1:0]  len,
                                                     input logic [TIME_W-1:0] now);
        session_reply_t   r;
        logic             good;
        logic [KEY_W-1:0] key;
        int               hit;
        int               victim;
        int               n;
        good = legal_id(chars, len);
        key  = chars & length_mask(len);
        r.ok = 1'b0;
        case (op)
            OP_TOUCH:
            begin
                if (good)
                begin
                    expire_idle(now);
                    hit = find_session(key, len);
                    if (hit < 0)
                    begin
                        victim = -1;
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (!shadow_active[i] && victim < 0)
                                victim = i;
                        end
                        // Table full: oldest last-seen time, lowest index on ties.
                        if (victim < 0)
                        begin
                            victim = 0;
                            for (int i = 1; i < CAPACITY; i++)
                            begin
                                if (shadow_seen[i] < shadow_seen[victim])
                                    victim = i;
                            end
                        end
                        shadow_key[victim]    = key;
                        shadow_len[victim]    = len;
                        shadow_active[victim] = 1'b1;
                        hit = victim;
                    end
                    shadow_seen[hit] = now;
                    r.ok = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (good)
                begin
                    hit = find_session(key, len);
                    if (hit >= 0)
                    begin
                        wipe_shadow_slot(hit);
                        r.ok = 1'b1;
                    end
                end
            end
            OP_COUNT:
            begin
                expire_idle(now);
                r.ok = 1'b1;
            end
            default:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    wipe_shadow_slot(i);
                r.ok = 1'b1;
            end
        endcase
        n = 0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (shadow_active[i])
                n++;
        end
        r.live_count = OUT_CNT_W'(n);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog, predictor and response checker
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Any transfer on either channel resets the stall counter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_ticks <= 0;
            else
                idle_ticks <= idle_ticks + 1;
            if (idle_ticks >= STALL_LIMIT)
            begin
                $display("%0t: watchdog, no transfer for %0d cycles, %0d replies pending",
                         $time, idle_ticks, pending_replies.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Register writes and accepted requests update the shadow timeout and table.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                shadow_timeout = (cfg_data == '0) ? TIME_W'(1) : cfg_data;
            if (req_ch.valid && req_ch.ready)
                pending_replies.push_back(apply_request(req_ch.operation, req_ch.id_chars,
                                                        req_ch.id_length, req_ch.now_ms));
        end
    end

    always @(posedge clk)
    begin
        session_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with none pending, got ok %0b count %0d",
                         $time, rsp_ch.ok, rsp_ch.live_count);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_ch.ok !== want.ok)
                begin
                    $display("%0t: ok mismatch, expected %0b actual %0b",
                             $time, want.ok, rsp_ch.ok);
                    error_count++;
                end
                if (rsp_ch.live_count !== want.live_count)
                begin
                    $display("%0t: live_count mismatch, expected %0d actual %0d",
                             $time, want.live_count, rsp_ch.live_count);
                    error_count++;
                end
            end
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Response back-pressure; now and then a long run with ready held high.
    initial
    begin
        int unsigned n;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat (150) @(negedge clk);
            else
                repeat ($urandom_range(0, 7)) @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks (all entered and left on a falling edge)
    // ------------------------------------------------------------------
    // One request transfer; valid stays high into the next call when no gap.
    task automatic send_request(input logic [OP_W-1:0]   op,
                                input logic [KEY_W-1:0]  chars,
                                input logic [LEN_W-1:0]  len,
                                input logic [TIME_W-1:0] now);
        int unsigned gap;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.id_chars  <= chars;
        req_ch.id_length <= len;
        req_ch.now_ms    <= now;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold off the sender until every reply is back and the block is quiet.
    task automatic wait_all_replies();
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TIME_W-1:0] value);
        wait_all_replies();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] random_legal_char();
        int unsigned k;
        k = $urandom_range(0, 63);
        if (k < 10)
            return 8'("0" + k);
        else if (k < 36)
            return 8'("A" + k - 10);
        else if (k < 62)
            return 8'("a" + k - 36);
        else if (k == 62)
            return "-";
        return "_";
    endfunction

    function automatic logic [KEY_W-1:0] random_legal_id();
        logic [KEY_W-1:0] c;
        for (int b = 0; b < KEY_W / 8; b++)
            c[b*8 +: 8] = random_legal_char();
        return c;
    endfunction

    // Random junk above the length; the block must ignore it.
    function automatic logic [KEY_W-1:0] with_junk(input logic [KEY_W-1:0] chars,
                                                   input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] junk;
        junk = {$urandom, $urandom};
        return (chars & length_mask(len)) | (junk & ~length_mask(len));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        // Empty table straight out of reset.
        send_request(OP_COUNT, '0, '0, '0);
    endtask

    task automatic test_id_checks();
        // Length outside 6..8, both field extremes included.
        send_request(OP_TOUCH, "abcdefgh", 4'd0, 32'd10);
        send_request(OP_TOUCH, "abcdefgh", 4'd5, 32'd10);
        send_request(OP_TOUCH, "abcdefgh", 4'd9, 32'd10);
        send_request(OP_TOUCH, "abcdefgh", 4'd15, 32'd10);
        // Every edge of the legal ranges, full length.
        send_request(OP_TOUCH, {"Z", "a", "_", "-", "9", "z", "A", "0"}, 4'd8, 32'd20);
        // Shortest id, bytes above the length set to junk.
        send_request(OP_TOUCH, {8'hFF, 8'h00, "_", "z", "a", "Z", "A", "9"}, 4'd6, 32'd30);
        // Illegal characters inside the length.
        send_request(OP_TOUCH, {"abc", 8'h7B, "defg"}, 4'd8, 32'd40);
        send_request(OP_TOUCH, {8'h00, "ab", 8'hFF, "cdef"}, 4'd7, 32'd40);
        send_request(OP_TOUCH, {8'h00, "abc", 8'h00, "def"}, 4'd7, 32'd40);
    endtask

    task automatic test_release();
        // No match, then the short id again under different junk bytes.
        send_request(OP_RELEASE, "unknown1", 4'd8, 32'd50);
        send_request(OP_RELEASE, {8'h12, 8'h34, "_", "z", "a", "Z", "A", "9"}, 4'd6, 32'd50);
        // Illegal id on release.
        send_request(OP_RELEASE, 64'("short"), 4'd5, 32'd50);
    endtask

    task automatic test_lru_replace();
        // Fill the table with equal times; the next new id must take slot 0.
        send_request(OP_CLEAR, {$urandom, $urandom}, 4'($urandom), $urandom);
        for (int i = 0; i <= CAPACITY; i++)
            send_request(OP_TOUCH, random_legal_id(), 4'd8, 32'd1000);
    endtask

    task automatic test_expiry_edges();
        // Age equal to the reset timeout keeps the slots, one more drops them.
        send_request(OP_COUNT, '0, '0, 32'd1000 + TIMEOUT_RESET);
        send_request(OP_COUNT, '0, '0, 32'd1001 + TIMEOUT_RESET);
    endtask

    task automatic test_timeout_extremes();
        logic [KEY_W-1:0] id;
        id = random_legal_id();
        // Zero is stored as one.
        write_timeout('0);
        send_request(OP_TOUCH, id, 4'd7, 32'd500);
        send_request(OP_COUNT, '0, '0, 32'd501);
        send_request(OP_COUNT, '0, '0, 32'd502);
        // Largest timeout: nothing can expire, even across the wrap.
        write_timeout('1);
        send_request(OP_TOUCH, id, 4'd7, 32'hFFFF_FFF0);
        send_request(OP_COUNT, '0, '0, 32'd5);
        send_request(OP_COUNT, '0, '0, 32'hFFFF_FFEF);
    endtask

    // One traffic phase at a given timeout and maximum time step.
    task automatic run_traffic_phase(input logic [TIME_W-1:0] timeout,
                                     input logic [TIME_W-1:0] step_max,
                                     input int unsigned       items);
        logic [TIME_W-1:0] now;
        logic [KEY_W-1:0]  chars;
        logic [LEN_W-1:0]  len;
        int unsigned       r;
        int unsigned       k;
        int unsigned       pos;
        write_timeout(timeout);
        now = $urandom;
        for (int unsigned n = 0; n < items; n++)
        begin
            if (n % 100 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 149) == 0)
                wait_all_replies();
            if ($urandom_range(0, 49) == 0)
                now = $urandom;
            else
                now = now + $urandom_range(0, step_max);
            k     = $urandom_range(0, 11);
            len   = pool_len[k];
            chars = with_junk(pool_chars[k], len);
            r     = $urandom_range(0, 99);
            if (r < 48)
                send_request(OP_TOUCH, chars, len, now);
            else if (r < 66)
                send_request(OP_RELEASE, chars, len, now);
            else if (r < 80)
                send_request(OP_COUNT, {$urandom, $urandom}, 4'($urandom), now);
            else if (r < 83)
                send_request(OP_CLEAR, {$urandom, $urandom}, 4'($urandom), now);
            else if (r < 91)
                send_request(OP_W'($urandom), {$urandom, $urandom}, 4'($urandom), now);
            else
            begin
                // Pool id with one character broken.
                pos = $urandom_range(0, len - 1);
                chars[pos*8 +: 8] = odd_chars[$urandom_range(0, 9)];
                send_request($urandom_range(0, 1) ? OP_TOUCH : OP_RELEASE, chars, len, now);
            end
        end
        sender_burst = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < 12; k++)
        begin
            pool_chars[k] = random_legal_id();
            pool_len[k]   = LEN_W'(MIN_ID_LEN + k % 3);
        end
        // Two ids that differ only in length.
        pool_len[10]   = 4'd8;
        pool_len[11]   = 4'd6;
        pool_chars[11] = pool_chars[10] & length_mask(4'd6);

        run_traffic_phase('0, 32'd2, 300);
        run_traffic_phase(32'd20, 32'd12, 320);
        run_traffic_phase(TIMEOUT_RESET, 32'd30000, 320);
        run_traffic_phase('1, '1, 300);
        run_traffic_phase($urandom, $urandom, 320);
        run_traffic_phase(32'd1, 32'd1, 320);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_TOUCH;
        req_ch.id_chars  = '0;
        req_ch.id_length = '0;
        req_ch.now_ms    = '0;
        error_count      = 0;
        idle_ticks       = 0;
        sender_burst     = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            wipe_shadow_slot(i);
        shadow_timeout = TIMEOUT_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_id_checks();
        test_release();
        test_lru_replace();
        test_expiry_edges();
        test_timeout_extremes();
        test_random_traffic();

        // Drain, then a few quiet cycles for anything stray.
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (4 * SETTLE_TICKS) @(negedge clk);

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: session_table_with_timeout_lru_top.f
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_ram.sv
rtl/session_table_with_timeout_lru_top.sv
verif/session_table_with_timeout_lru_top_test.sv
